/* hw/rtl/gww_pkg.sv */
// Shared types and constants for the greedy word wrap block.
// Used by gww_front, gww_back and the top level; depends on nothing.
package gww_pkg;

  localparam int unsigned MaxWidthDef = 32;
  localparam int unsigned CfgW        = 6;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [CfgW-1:0] WidthReset = 6'd16;

  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharHyphen  = 8'd45;
  localparam logic [7:0] CharNewline = 8'd10;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } gww_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } gww_out_t;

  typedef enum logic [1:0] {
    CLS_CHAR,
    CLS_SEP,
    CLS_EOT
  } gww_cls_e;

  typedef struct packed {
    gww_cls_e   cls;
    logic [7:0] text_byte;
  } gww_item_t;

  typedef struct packed {
    logic      valid;
    gww_item_t item;
  } gww_queue_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_RUN,
    ST_HYPH,
    ST_NL,
    ST_EOT
  } gww_state_e;

endpackage

/* hw/rtl/greedy_word_wrap_with_hyphen_split.sv */
// Greedy word wrap with hyphen split. Bytes enter a two-entry queue at up to
// one per cycle; a byte that only extends the pending word is popped as soon as
// it reaches the head of the queue, so plain text streams at one byte per cycle.
// A space or end of text that closes a word holds the back-end sequencer while
// it emits the separator and the pending word, which is read out of its buffer
// one byte per cycle unless the output stalls; the queue stalls the input once full.
// Results leave through an output register. Writing the line width (cfg_we_i)
// restarts the text. Depends on gww_pkg, gww_front and gww_back.
module greedy_word_wrap_with_hyphen_split #(
  parameter int unsigned MAX_WIDTH = gww_pkg::MaxWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  gww_pkg::gww_in_t          in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gww_pkg::gww_out_t         out_o,
  input  logic                      cfg_we_i,
  input  logic [gww_pkg::CfgW-1:0]  cfg_wdata_i
);

  gww_pkg::gww_queue_t queue;
  logic                pop;

  gww_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_o        (queue),
    .pop_i      (pop)
  );

  gww_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (queue),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

/* hw/rtl/gww_front.sv */
// Input side of the word wrap block: accepts bytes, classifies them and
// holds them in a short queue for the back end. Depends on gww_pkg.
module gww_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gww_pkg::gww_in_t    in_i,
  output gww_pkg::gww_queue_t q_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = $clog2(gww_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(gww_pkg::QueueDepth + 1);

  gww_pkg::gww_item_t entry_q [gww_pkg::QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    fill_q, fill_d;
  gww_pkg::gww_item_t item_in;
  logic               push;
  logic               pop;

  always_comb begin
    item_in.text_byte = in_i.text_byte;
    if (in_i.end_of_text) begin
      item_in.cls = gww_pkg::CLS_EOT;
    end else if (in_i.text_byte == gww_pkg::CharSpace) begin
      item_in.cls = gww_pkg::CLS_SEP;
    end else begin
      item_in.cls = gww_pkg::CLS_CHAR;
    end
  end

  assign in_stall_o = (fill_q == CntW'(gww_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (fill_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(gww_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(gww_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

  assign q_o.valid = (fill_q != '0);
  assign q_o.item  = entry_q[rd_ptr_q];

endmodule

/* hw/rtl/gww_back.sv */
// Back end of the word wrap block: pending-word store, line state and the
// sequencer that emits wrapped bytes. Depends on gww_pkg.
module gww_back #(
  parameter int unsigned MAX_WIDTH = gww_pkg::MaxWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gww_pkg::gww_queue_t       q_i,
  output logic                      pop_o,
  input  logic                      cfg_we_i,
  input  logic [gww_pkg::CfgW-1:0]  cfg_wdata_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gww_pkg::gww_out_t         out_o
);

  localparam int unsigned CFG_W  = gww_pkg::CfgW;
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam logic [CFG_W-1:0] MinCfg = CFG_W'(2);
  localparam logic [CFG_W-1:0] MaxCfg = CFG_W'(MAX_WIDTH);

  // The pending word lives in a circular buffer so that a split word keeps
  // its remainder in place.
  logic [7:0]          store_q [DEPTH];
  logic [7:0]          rd_data_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;

  gww_pkg::gww_state_e state_q, state_d;
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    line_len_q, line_len_d;
  logic                fresh_q, fresh_d;
  logic                long_q, long_d;
  logic [CFG_W-1:0]    width_q, width_d;
  logic [CNT_W-1:0]    run_left_q, run_left_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic                split_q, split_d;
  logic                long_nl_q, long_nl_d;
  logic                eot_nl_q, eot_nl_d;
  logic [7:0]          pre_q, pre_d;
  logic                out_valid_q, out_valid_d;
  gww_pkg::gww_out_t   out_q, out_d;

  logic [CNT_W-1:0]    w;
  logic [CNT_W-1:0]    wm1;
  logic [CNT_W:0]      len_sum;
  logic                fits;
  logic [CNT_W-1:0]    new_len;
  logic                split_go;
  logic                emit;
  logic                emit_ok;
  logic [7:0]          emit_byte;
  logic                emit_last;

  always_comb begin
    if (width_q < MinCfg) begin
      w = CNT_W'(2);
    end else if (width_q > MaxCfg) begin
      w = CNT_W'(MAX_WIDTH);
    end else begin
      w = width_q[CNT_W-1:0];
    end
  end

  assign wm1      = w - CNT_W'(1);
  assign len_sum  = {1'b0, line_len_q} + (CNT_W + 1)'(1) + {1'b0, count_q};
  assign fits     = (len_sum <= {1'b0, w});
  assign split_go = long_q ? (count_q >= wm1) : (count_q >= w);
  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign wr_addr  = head_q + count_q[ADDR_W-1:0];
  assign rd_addr  = head_d;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    line_len_d = line_len_q;
    fresh_d    = fresh_q;
    long_d     = long_q;
    width_d    = width_q;
    run_left_d = run_left_q;
    rem_d      = rem_q;
    split_d    = split_q;
    long_nl_d  = long_nl_q;
    eot_nl_d   = eot_nl_q;
    pre_d      = pre_q;
    new_len    = line_len_q;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    emit_byte  = rd_data_q;
    emit_last  = 1'b0;

    case (state_q)
      gww_pkg::ST_IDLE: begin
        if (q_i.valid && !cfg_we_i) begin
          pop_o = 1'b1;
          case (q_i.item.cls)
            gww_pkg::CLS_CHAR: begin
              wr_en = 1'b1;
              if (split_go) begin
                // The word no longer fits any line: cut it into pieces.
                split_d    = 1'b1;
                rem_d      = count_q + CNT_W'(1);
                run_left_d = wm1;
                count_d    = '0;
                long_d     = 1'b1;
                fresh_d    = 1'b1;
                line_len_d = '0;
                if (!long_q && !fresh_q) begin
                  pre_d   = gww_pkg::CharNewline;
                  state_d = gww_pkg::ST_PRE;
                end else begin
                  state_d = gww_pkg::ST_RUN;
                end
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            default: begin
              if (count_q != '0) begin
                run_left_d = count_q;
                count_d    = '0;
                split_d    = 1'b0;
                state_d    = gww_pkg::ST_RUN;
                if (long_q) begin
                  long_nl_d = 1'b1;
                  long_d    = 1'b0;
                end else if (fresh_q) begin
                  new_len = count_q;
                  fresh_d = 1'b0;
                end else if (fits) begin
                  new_len = len_sum[CNT_W-1:0];
                  pre_d   = gww_pkg::CharSpace;
                  state_d = gww_pkg::ST_PRE;
                end else begin
                  new_len = count_q;
                  pre_d   = gww_pkg::CharNewline;
                  state_d = gww_pkg::ST_PRE;
                end
                line_len_d = new_len;
              end
              eot_nl_d = (q_i.item.cls == gww_pkg::CLS_EOT) && (new_len != '0);
              if (q_i.item.cls == gww_pkg::CLS_EOT) begin
                line_len_d = '0;
                fresh_d    = 1'b1;
                long_d     = 1'b0;
                if (count_q == '0 && new_len != '0) begin
                  state_d = gww_pkg::ST_EOT;
                end
              end
            end
          endcase
        end
      end
      gww_pkg::ST_PRE: begin
        emit      = 1'b1;
        emit_byte = pre_q;
        if (emit_ok) begin
          state_d = gww_pkg::ST_RUN;
        end
      end
      gww_pkg::ST_RUN: begin
        emit      = 1'b1;
        emit_byte = rd_data_q;
        emit_last = (run_left_q == CNT_W'(1)) && !split_q && !long_nl_q && !eot_nl_q;
        if (emit_ok) begin
          head_d     = head_q + ADDR_W'(1);
          run_left_d = run_left_q - CNT_W'(1);
          if (split_q) begin
            rem_d = rem_q - CNT_W'(1);
          end
          if (run_left_q == CNT_W'(1)) begin
            if (split_q) begin
              state_d = gww_pkg::ST_HYPH;
            end else if (long_nl_q) begin
              state_d = gww_pkg::ST_NL;
            end else if (eot_nl_q) begin
              state_d = gww_pkg::ST_EOT;
            end else begin
              state_d = gww_pkg::ST_IDLE;
            end
          end
        end
      end
      gww_pkg::ST_HYPH: begin
        emit      = 1'b1;
        emit_byte = gww_pkg::CharHyphen;
        if (emit_ok) begin
          state_d = gww_pkg::ST_NL;
        end
      end
      gww_pkg::ST_NL: begin
        emit      = 1'b1;
        emit_byte = gww_pkg::CharNewline;
        emit_last = split_q ? !(rem_q > wm1) : !eot_nl_q;
        if (emit_ok) begin
          long_nl_d = 1'b0;
          if (split_q) begin
            if (rem_q > wm1) begin
              run_left_d = wm1;
              state_d    = gww_pkg::ST_RUN;
            end else begin
              // What is left of the split word stays pending.
              count_d = rem_q;
              split_d = 1'b0;
              state_d = gww_pkg::ST_IDLE;
            end
          end else if (eot_nl_q) begin
            state_d = gww_pkg::ST_EOT;
          end else begin
            state_d = gww_pkg::ST_IDLE;
          end
        end
      end
      gww_pkg::ST_EOT: begin
        emit      = 1'b1;
        emit_byte = gww_pkg::CharNewline;
        emit_last = 1'b1;
        if (emit_ok) begin
          eot_nl_d = 1'b0;
          state_d  = gww_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gww_pkg::ST_IDLE;
      end
    endcase

    // A width write restarts the text.
    if (cfg_we_i) begin
      width_d    = cfg_wdata_i;
      count_d    = '0;
      line_len_d = '0;
      fresh_d    = 1'b1;
      long_d     = 1'b0;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit && emit_ok) begin
      out_d.out_byte    = emit_byte;
      out_d.last_of_run = emit_last;
      out_valid_d       = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gww_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      line_len_q  <= '0;
      fresh_q     <= 1'b1;
      long_q      <= 1'b0;
      width_q     <= gww_pkg::WidthReset;
      run_left_q  <= '0;
      rem_q       <= '0;
      split_q     <= 1'b0;
      long_nl_q   <= 1'b0;
      eot_nl_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      line_len_q  <= line_len_d;
      fresh_q     <= fresh_d;
      long_q      <= long_d;
      width_q     <= width_d;
      run_left_q  <= run_left_d;
      rem_q       <= rem_d;
      split_q     <= split_d;
      long_nl_q   <= long_nl_d;
      eot_nl_q    <= eot_nl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= q_i.item.text_byte;
    end
    rd_data_q <= store_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
